@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the laplacian edge filter
// no dependencies; taken in by `include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/lapedge_pkg.sv @@
// types and fixed constants of the 3x3 laplacian edge filter
// no dependencies; the top level and its submodules refer to it by scoped names
package lapedge_pkg;

	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 16;
	localparam int ROW_W       = 17;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// op field of an input beat
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

	localparam logic [7:0] PIX_MAX = 8'd255;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// one line store entry: row two above and row above the input row
	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
	} line_word_t;

	// edge replacement and output marks for one window position
	typedef struct packed {
		logic lc;
		logic rc;
		logic ur;
		logic dr;
		logic emit;
		logic last;
	} win_flags_t;

	typedef struct packed {
		rgb_t pix;
		logic last;
	} result_t;

endpackage

@@ rtl/lapedge_in_if.sv @@
// input pixel channel: valid/ready with op and the three colour channels
// no dependencies
interface lapedge_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, output op, output in_red, output in_green,
		output in_blue, input ready);
	modport sink (input valid, input op, input in_red, input in_green,
		input in_blue, output ready);
endinterface

@@ rtl/lapedge_out_if.sv @@
// result channel: valid/ready with the filtered pixel and the frame-end mark
// no dependencies
interface lapedge_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last_of_frame;

	modport source (output valid, output out_red, output out_green,
		output out_blue, output last_of_frame, input ready);
	modport sink (input valid, input out_red, input out_green,
		input out_blue, input last_of_frame, output ready);
endinterface

@@ rtl/laplacian_edge_3x3_rgb.sv @@
// top level of the 3x3 laplacian edge filter on rgb raster streams
// depends on lapedge_pkg, both channel interfaces and the lapedge_* submodules
//
// pix_in takes one pixel beat per cycle while ready is high, in raster order
// (op = 0); after the frame, image_width + 1 beats with op = 1 flush the remaining results.
// pix_out gives one result beat per window centre inside the frame; the beat
// for the last pixel of the frame carries last_of_frame. The result for a
// pixel is caused by the input beat one row and one column later.
// an accepted beat passes the line memory read register, the window register and
// the result queue before its result shows on pix_out; throughput is one beat
// per cycle while pix_in.ready is high, set by the line memory taking one read
// and one write each cycle, with forwarding when consecutive beats hit the same column (narrow frames).
// a four-entry result queue absorbs receiver stalls; pix_in.ready drops only
// when the queue plus the beats still in the pipeline would overfill it.
// cfg_we writes image_width (index 0) or image_height (index 1);
// write only while the block is idle.
// reset clears the positions, the window and the queue and loads 640x480;
// the line memory is not cleared, rows read before being written are edge
// rows and are replaced by the replication rule.
module laplacian_edge_3x3_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lapedge_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lapedge_pkg::CFG_DATA_W-1:0]   cfg_data,
	lapedge_in_if.sink                           pix_in,
	lapedge_out_if.source                        pix_out
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int LW = lapedge_pkg::FIFO_LVL_W;

	logic                    accept;
	logic [AW-1:0]           addr;
	lapedge_pkg::win_flags_t flags;
	lapedge_pkg::rgb_t       px;
	lapedge_pkg::rgb_t       top_px;
	lapedge_pkg::rgb_t       mid_px;
	lapedge_pkg::rgb_t       cur_px;
	logic [1:0]              inflight;
	logic                    push;
	lapedge_pkg::result_t    result;
	logic [LW-1:0]           level;
	logic [LW-1:0]           occupancy;

	always_comb begin
		// credit: every beat in flight may still need a queue slot
		occupancy    = level + LW'(inflight);
		pix_in.ready = (occupancy < LW'(lapedge_pkg::FIFO_DEPTH));
		accept       = pix_in.valid && pix_in.ready;
		// drain beats enter as black pixels
		if (pix_in.op == lapedge_pkg::OP_DRAIN) begin
			px = '0;
		end else begin
			px.red   = pix_in.in_red;
			px.green = pix_in.in_green;
			px.blue  = pix_in.in_blue;
		end
	end

	lapedge_seq #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.addr      (addr),
		.flags     (flags)
	);

	lapedge_line_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (accept),
		.addr   (addr),
		.px     (px),
		.top_px (top_px),
		.mid_px (mid_px),
		.cur_px (cur_px)
	);

	lapedge_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.flags    (flags),
		.top_px   (top_px),
		.mid_px   (mid_px),
		.cur_px   (cur_px),
		.inflight (inflight),
		.push     (push),
		.result   (result)
	);

	lapedge_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.level     (level),
		.pix_out   (pix_out)
	);

endmodule

@@ rtl/lapedge_seq.sv @@
// position sequencer: config registers, raster column/row counters and
// per-window edge flags; depends on lapedge_pkg
module lapedge_seq #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lapedge_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lapedge_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                 accept,
	output logic [$clog2(MAX_WIDTH)-1:0]         addr,
	output lapedge_pkg::win_flags_t              flags
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = lapedge_pkg::ROW_W;

	logic [lapedge_pkg::WIDTH_W-1:0]  width_q;
	logic [lapedge_pkg::HEIGHT_W-1:0] height_q;
	logic [AW-1:0]                    col_q;
	logic [RW-1:0]                    row_q;

	logic [CW-1:0] weff;
	logic [CW-1:0] weff_m1;
	logic [lapedge_pkg::HEIGHT_W-1:0] heff;
	logic [RW-1:0] heff_m1;
	logic          wrap0;
	logic [AW-1:0] x;
	logic [RW-1:0] y;
	logic [CW-1:0] x_c;
	logic [CW-1:0] x1;
	logic [CW-1:0] cx;
	logic [RW-1:0] cy;
	logic          have;
	logic [AW-1:0] x_nxt;
	logic [RW-1:0] y_nxt;
	logic          emit;
	logic          last_hit;

	always_comb begin
		if (width_q == '0) begin
			weff = CW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			weff = CW'(MAX_WIDTH);
		end else begin
			weff = CW'(width_q);
		end
		weff_m1 = weff - CW'(1);
		heff    = (height_q == '0) ? lapedge_pkg::HEIGHT_W'(1) : height_q;
		heff_m1 = RW'(heff) - RW'(1);
	end

	// a column left beyond a narrowed width wraps to the next row first
	always_comb begin
		wrap0 = (CW'(col_q) >= weff);
		x     = wrap0 ? '0 : col_q;
		y     = wrap0 ? (row_q + RW'(1)) : row_q;
		x_c   = CW'(x);

		// window centre lags the input by one row and one column
		if (x != '0) begin
			cx   = x_c - CW'(1);
			have = (y != '0);
			cy   = y - RW'(1);
		end else begin
			cx   = weff_m1;
			have = (y >= RW'(2));
			cy   = y - RW'(2);
		end

		x1 = x_c + CW'(1);
		if (x1 >= weff) begin
			x_nxt = '0;
			y_nxt = y + RW'(1);
		end else begin
			x_nxt = x1[AW-1:0];
			y_nxt = y;
		end

		emit     = have && (cy < RW'(heff));
		last_hit = (cx == weff_m1) && (cy == heff_m1);
	end

	always_comb begin
		addr       = x;
		flags.lc   = (cx == '0);
		flags.rc   = (cx == weff_m1);
		flags.ur   = (cy == '0);
		flags.dr   = (cy == heff_m1);
		flags.emit = emit;
		flags.last = last_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lapedge_pkg::WIDTH_RESET;
			height_q <= lapedge_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lapedge_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[lapedge_pkg::WIDTH_W-1:0];
				end
				lapedge_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[lapedge_pkg::HEIGHT_W-1:0];
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			// the final result of a frame restarts the raster at the origin
			if (emit && last_hit) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				col_q <= x_nxt;
				row_q <= y_nxt;
			end
		end
	end

endmodule

@@ rtl/lapedge_line_mem.sv @@
// line store: one synchronous memory holding the two previous rows per column,
// read-modify-write with forwarding; depends on lapedge_pkg and assert_macros.svh
`include "assert_macros.svh"

module lapedge_line_mem #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req,
	input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
	input  lapedge_pkg::rgb_t             px,
	output lapedge_pkg::rgb_t             top_px,
	output lapedge_pkg::rgb_t             mid_px,
	output lapedge_pkg::rgb_t             cur_px
);

	localparam int AW = $clog2(MAX_WIDTH);

	lapedge_pkg::line_word_t mem [MAX_WIDTH];

	logic                    v_s1;
	logic [AW-1:0]           addr_s1;
	lapedge_pkg::rgb_t       px_s1;
	lapedge_pkg::line_word_t rd_q;
	logic                    fwd_q;
	lapedge_pkg::line_word_t fwd_word_q;
	lapedge_pkg::line_word_t word;
	lapedge_pkg::line_word_t wr_word;

	always_comb begin
		// back-to-back beats on one column read before the write lands
		word           = fwd_q ? fwd_word_q : rd_q;
		wr_word.upper  = word.middle;
		wr_word.middle = px_s1;
		top_px         = word.upper;
		mid_px         = word.middle;
		cur_px         = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			v_s1  <= req;
			fwd_q <= req && v_s1 && (addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			addr_s1 <= addr;
			px_s1   <= px;
		end
		fwd_word_q <= wr_word;
	end

	always_ff @(posedge clk) begin
		if (req) begin
			rd_q <= mem[addr];
		end
		if (v_s1) begin
			mem[addr_s1] <= wr_word;
		end
	end

	`ASSERT_IMPLY(a_fwd_needed, clk, arst_n, v_s1 && $past(v_s1) && (addr_s1 == $past(addr_s1)), fwd_q, "same column on consecutive beats but no forward")
	`ASSERT_IMPLY(a_fwd_justified, clk, arst_n, fwd_q, v_s1 && $past(v_s1) && (addr_s1 == $past(addr_s1)), "forward taken without a pending write to the column")

endmodule

@@ rtl/lapedge_filter.sv @@
// 3x3 window shift register and per-channel laplacian with edge replication
// and clamping; depends on lapedge_pkg
module lapedge_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  lapedge_pkg::win_flags_t   flags,
	input  lapedge_pkg::rgb_t         top_px,
	input  lapedge_pkg::rgb_t         mid_px,
	input  lapedge_pkg::rgb_t         cur_px,
	output logic [1:0]                inflight,
	output logic                      push,
	output lapedge_pkg::result_t      result
);

	logic                    v_s1;
	logic                    v_s2;
	lapedge_pkg::win_flags_t flags_s1;
	lapedge_pkg::win_flags_t flags_s2;
	lapedge_pkg::rgb_t       win_q [9];

	lapedge_pkg::rgb_t up [3];
	lapedge_pkg::rgb_t md [3];
	lapedge_pkg::rgb_t dn [3];
	logic [23:0]       nb [8];
	logic [23:0]       ctr;
	logic [23:0]       res_bits;

	function automatic logic [7:0] clamp_byte(input logic signed [12:0] d);
		logic [7:0] r;
		if (d[12]) begin
			r = 8'd0;
		end else if (d[11:8] != 4'd0) begin
			r = lapedge_pkg::PIX_MAX;
		end else begin
			r = d[7:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
		end
		flags_s2 <= flags_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= top_px;
			win_q[5] <= mid_px;
			win_q[8] <= cur_px;
		end
	end

	// rows and columns past the frame edge fall back to the centre ones
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			md[c] = win_q[3 + c];
			up[c] = flags_s2.ur ? win_q[3 + c] : win_q[c];
			dn[c] = flags_s2.dr ? win_q[3 + c] : win_q[6 + c];
		end
		nb[0] = flags_s2.lc ? up[1] : up[0];
		nb[1] = up[1];
		nb[2] = flags_s2.rc ? up[1] : up[2];
		nb[3] = flags_s2.lc ? md[1] : md[0];
		nb[4] = flags_s2.rc ? md[1] : md[2];
		nb[5] = flags_s2.lc ? dn[1] : dn[0];
		nb[6] = dn[1];
		nb[7] = flags_s2.rc ? dn[1] : dn[2];
		ctr   = md[1];
	end

	always_comb begin
		logic [10:0]        sum;
		logic signed [12:0] diff;
		res_bits = '0;
		for (int ch = 0; ch < 3; ch++) begin
			sum = '0;
			for (int k = 0; k < 8; k++) begin
				sum = sum + 11'(nb[k][ch*8 +: 8]);
			end
			diff = $signed({2'b00, ctr[ch*8 +: 8], 3'b000}) - $signed({2'b00, sum});
			res_bits[ch*8 +: 8] = clamp_byte(diff);
		end
	end

	always_comb begin
		push        = v_s2 && flags_s2.emit;
		result.pix  = lapedge_pkg::rgb_t'(res_bits);
		result.last = flags_s2.last;
		inflight    = 2'(v_s1) + 2'(v_s2);
	end

endmodule

@@ rtl/lapedge_out_fifo.sv @@
// result queue in front of the output channel; decouples the fixed-latency
// pipeline from receiver stalls; depends on lapedge_pkg, lapedge_out_if, assert_macros.svh
`include "assert_macros.svh"

module lapedge_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  lapedge_pkg::result_t                push_data,
	output logic [lapedge_pkg::FIFO_LVL_W-1:0]  level,
	lapedge_out_if.source                       pix_out
);

	localparam int PW = lapedge_pkg::FIFO_PTR_W;
	localparam int LW = lapedge_pkg::FIFO_LVL_W;

	lapedge_pkg::result_t entries [lapedge_pkg::FIFO_DEPTH];

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] count_q;
	logic          pop;
	lapedge_pkg::result_t head;

	always_comb begin
		head                  = entries[rd_ptr_q];
		pix_out.valid         = (count_q != '0);
		pix_out.out_red       = head.pix.red;
		pix_out.out_green     = head.pix.green;
		pix_out.out_blue      = head.pix.blue;
		pix_out.last_of_frame = head.last;
		pop                   = pix_out.valid && pix_out.ready;
		level                 = count_q;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + LW'(push) - LW'(pop);
		end
	end

	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, push && !pop, count_q < LW'(lapedge_pkg::FIFO_DEPTH), "result beat pushed into a full queue")
	`ASSERT_ALWAYS(a_ptr_level, clk, arst_n, (wr_ptr_q - rd_ptr_q) == count_q[PW-1:0], "queue pointers disagree with fill level")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// testbench for laplacian_edge_3x3_rgb: raster frames in, clamped laplacian beats out
// depends on lapedge_pkg, lapedge_in_if, lapedge_out_if and the filter rtl
module testbench;

	localparam int unsigned MAX_W = 1024;

	typedef enum int unsigned {PAT_RANDOM, PAT_CHECKER, PAT_IMPULSE, PAT_FLAT} pattern_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lapedge_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lapedge_pkg::CFG_DATA_W-1:0] cfg_data;

	lapedge_in_if pix_in ();
	lapedge_out_if pix_out ();

	laplacian_edge_3x3_rgb dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_in(pix_in),
		.pix_out(pix_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// filter state as seen from the stream
	logic [lapedge_pkg::WIDTH_W-1:0] width_reg = lapedge_pkg::WIDTH_RESET;
	logic [lapedge_pkg::HEIGHT_W-1:0] height_reg = lapedge_pkg::HEIGHT_RESET;
	logic [23:0] upper_line [MAX_W] = '{default: '0};
	logic [23:0] middle_line [MAX_W] = '{default: '0};
	logic [23:0] window_px [9] = '{default: '0};
	logic [lapedge_pkg::WIDTH_W-1:0] col_pos = '0;
	logic [lapedge_pkg::ROW_W-1:0] row_pos = '0;

	lapedge_pkg::result_t filtered_pixels [$];
	int mismatches = 0;
	int unsigned beats_sent = 0;
	bit steady = 1'b0;

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		return (width_reg > MAX_W) ? MAX_W : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic logic [7:0] laplace_channel(input int unsigned sh, input int unsigned lc,
			input int unsigned rc, input int unsigned ur, input int unsigned dr);
		int unsigned rows [3];
		int unsigned cols [3];
		int acc;
		rows = '{ur, 1, dr};
		cols = '{lc, 1, rc};
		acc = 8 * int'((window_px[4] >> sh) & 24'hFF);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (!(i == 1 && j == 1))
					acc -= int'((window_px[rows[i] * 3 + cols[j]] >> sh) & 24'hFF);
		if (acc > 255)
			acc = 255;
		if (acc < 0)
			acc = 0;
		return acc[7:0];
	endfunction

	// advances the filter by one beat; returns 1 when the beat yields a result
	function automatic bit laplacian_pixel(input logic op, input lapedge_pkg::rgb_t pix,
			output lapedge_pkg::result_t res);
		int unsigned weff, heff, x, y, cx, cy;
		logic [23:0] px, top, mid;
		bit have;
		weff = eff_width();
		heff = eff_height();
		x = col_pos;
		y = row_pos;
		res = '0;
		if (x >= weff) begin
			x = 0;
			y = (y + 1) & 32'h1FFFF;
		end
		px = (op == lapedge_pkg::OP_DRAIN) ? 24'd0 : pix;
		top = upper_line[x];
		mid = middle_line[x];
		upper_line[x] = mid;
		middle_line[x] = px;
		for (int r = 0; r < 3; r++) begin
			window_px[r * 3] = window_px[r * 3 + 1];
			window_px[r * 3 + 1] = window_px[r * 3 + 2];
		end
		window_px[2] = top;
		window_px[5] = mid;
		window_px[8] = px;
		if (x >= 1) begin
			cx = x - 1;
			have = (y >= 1);
			cy = y - 1;
		end else begin
			cx = weff - 1;
			have = (y >= 2);
			cy = y - 2;
		end
		x++;
		if (x >= weff) begin
			x = 0;
			y = (y + 1) & 32'h1FFFF;
		end
		col_pos = lapedge_pkg::WIDTH_W'(x);
		row_pos = lapedge_pkg::ROW_W'(y);
		if (!have || cy >= heff)
			return 1'b0;
		res.pix.red = laplace_channel(16, cx == 0, (cx == weff - 1) ? 1 : 2,
			cy == 0, (cy == heff - 1) ? 1 : 2);
		res.pix.green = laplace_channel(8, cx == 0, (cx == weff - 1) ? 1 : 2,
			cy == 0, (cy == heff - 1) ? 1 : 2);
		res.pix.blue = laplace_channel(0, cx == 0, (cx == weff - 1) ? 1 : 2,
			cy == 0, (cy == heff - 1) ? 1 : 2);
		res.last = (cx == weff - 1) && (cy == heff - 1);
		if (res.last) begin
			col_pos = '0;
			row_pos = '0;
		end
		return 1'b1;
	endfunction

	// channels lean towards the rails so that both clamps get hit
	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return lapedge_pkg::PIX_MAX;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic lapedge_pkg::rgb_t random_pixel();
		lapedge_pkg::rgb_t p;
		p.red = random_channel();
		p.green = random_channel();
		p.blue = random_channel();
		return p;
	endfunction

	function automatic lapedge_pkg::rgb_t pattern_pixel(input pattern_t pat,
			input int unsigned x, input int unsigned y);
		lapedge_pkg::rgb_t p;
		case (pat)
			PAT_CHECKER: begin
				p.red = ((x ^ y) & 1) ? lapedge_pkg::PIX_MAX : 8'd0;
				p.green = ~p.red;
				p.blue = ((x + y) % 3 == 0) ? lapedge_pkg::PIX_MAX : 8'd0;
			end
			PAT_IMPULSE: p = (x == 1 && y == 1) ? {3{lapedge_pkg::PIX_MAX}} : '0;
			PAT_FLAT: p = {8'd200, lapedge_pkg::PIX_MAX, 8'd1};
			default: p = random_pixel();
		endcase
		return p;
	endfunction

	task automatic send_beat(input logic op, input lapedge_pkg::rgb_t pix);
		lapedge_pkg::result_t res;
		while (!steady && $urandom_range(0, 99) < 14) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.op <= op;
		pix_in.in_red <= pix.red;
		pix_in.in_green <= pix.green;
		pix_in.in_blue <= pix.blue;
		do
			@(posedge clk);
		while (!pix_in.ready);
		if (laplacian_pixel(op, pix, res))
			filtered_pixels.push_back(res);
		beats_sent++;
	endtask

	task automatic send_random(input int unsigned count, input logic op);
		repeat (count)
			send_beat(op, random_pixel());
	endtask

	// runs on from the current position until the frame-end beat has been predicted
	task automatic stream_frame(input pattern_t pat, input int unsigned noise_pct);
		int unsigned x, y;
		do begin
			x = col_pos;
			y = row_pos;
			if (x >= eff_width()) begin
				x = 0;
				y = (y + 1) & 32'h1FFFF;
			end
			if (y >= eff_height() || $urandom_range(0, 99) < noise_pct)
				send_beat(lapedge_pkg::OP_DRAIN, random_pixel());
			else
				send_beat(lapedge_pkg::OP_PIXEL, pattern_pixel(pat, x, y));
		end while (col_pos != 0 || row_pos != 0);
	endtask

	// beats that yield nothing may still be in the pipe, so wait on past the last expected result
	task automatic wait_idle();
		pix_in.valid <= 1'b0;
		while (filtered_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lapedge_pkg::CFG_INDEX_W-1:0] idx,
			input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= lapedge_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lapedge_pkg::REG_IMAGE_WIDTH)
			width_reg = lapedge_pkg::WIDTH_W'(value);
		else
			height_reg = lapedge_pkg::HEIGHT_W'(value);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h);
		wait_idle();
		write_reg(lapedge_pkg::REG_IMAGE_WIDTH, w);
		write_reg(lapedge_pkg::REG_IMAGE_HEIGHT, h);
	endtask

	task automatic test_extreme_pixels();
		configure(4, 4);
		stream_frame(PAT_CHECKER, 0);
		stream_frame(PAT_IMPULSE, 0);
		stream_frame(PAT_FLAT, 0);
	endtask

	// zero width and height act as one
	task automatic test_frame_sizes();
		configure(1, 1);
		stream_frame(PAT_RANDOM, 0);
		configure(0, 0);
		stream_frame(PAT_RANDOM, 0);
		configure(2, 5);
		stream_frame(PAT_CHECKER, 0);
		configure(5, 2);
		stream_frame(PAT_RANDOM, 0);
	endtask

	// drain beats inside the frame count as black pixels
	task automatic test_drain_inside_frame();
		configure(5, 4);
		stream_frame(PAT_RANDOM, 30);
	endtask

	// beats after the flush open a new frame
	task automatic test_past_drain();
		configure(3, 2);
		stream_frame(PAT_RANDOM, 0);
		send_random(3, lapedge_pkg::OP_DRAIN);
		stream_frame(PAT_RANDOM, 0);
	endtask

	// narrower width lands on a column past the end and wraps to the next row
	task automatic test_config_mid_frame();
		configure(6, 8);
		send_random(3 * 6 + 5, lapedge_pkg::OP_PIXEL);
		configure(4, 7);
		stream_frame(PAT_RANDOM, 0);
	endtask

	task automatic test_random_frames();
		int unsigned start_count;
		int unsigned roll;
		start_count = beats_sent;
		while (beats_sent - start_count < 1050) begin
			steady = (beats_sent - start_count >= 300) && (beats_sent - start_count < 700);
			if (beats_sent == start_count || $urandom_range(0, 3) == 0) begin
				roll = $urandom_range(0, 19);
				if (roll == 0)
					configure($urandom_range(17, 64), $urandom_range(0, 4));
				else if (roll == 1)
					configure(0, $urandom_range(0, 9));
				else
					configure($urandom_range(1, 12), $urandom_range(1, 9));
			end
			case ($urandom_range(0, 9))
				0: stream_frame(PAT_RANDOM, 20);
				1: begin
					stream_frame(PAT_RANDOM, 0);
					send_random($urandom_range(1, 4), lapedge_pkg::OP_DRAIN);
					stream_frame(PAT_RANDOM, 0);
				end
				2: begin
					// stray beats of either kind before the frame proper
					repeat ($urandom_range(1, 5))
						send_beat(1'($urandom_range(0, 1)), random_pixel());
					stream_frame(PAT_RANDOM, 0);
				end
				default: stream_frame(PAT_RANDOM, 0);
			endcase
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		lapedge_pkg::result_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (filtered_pixels.size() == 0) begin
				$error("result beat with no pixel expected");
				mismatches++;
			end else begin
				want = filtered_pixels.pop_front();
				if (pix_out.out_red !== want.pix.red) begin
					$error("out_red: expected %0d, got %0d", want.pix.red, pix_out.out_red);
					mismatches++;
				end
				if (pix_out.out_green !== want.pix.green) begin
					$error("out_green: expected %0d, got %0d", want.pix.green, pix_out.out_green);
					mismatches++;
				end
				if (pix_out.out_blue !== want.pix.blue) begin
					$error("out_blue: expected %0d, got %0d", want.pix.blue, pix_out.out_blue);
					mismatches++;
				end
				if (pix_out.last_of_frame !== want.last) begin
					$error("last_of_frame: expected %0d, got %0d", want.last,
						pix_out.last_of_frame);
					mismatches++;
				end
			end
		end
		pix_out.ready <= steady || $urandom_range(0, 99) >= 14;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= lapedge_pkg::REG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix_in.valid <= 1'b0;
		pix_in.op <= lapedge_pkg::OP_PIXEL;
		pix_in.in_red <= '0;
		pix_in.in_green <= '0;
		pix_in.in_blue <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_extreme_pixels();
		test_frame_sizes();
		test_drain_inside_frame();
		test_past_drain();
		test_config_mid_frame();
		test_random_frames();

		wait_idle();
		if (mismatches == 0)
			$display("laplacian_edge_3x3_rgb: match");
		else
			$display("laplacian_edge_3x3_rgb: mismatch");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("laplacian_edge_3x3_rgb: mismatch");
		$finish;
	end

endmodule
